@@ src/rgaa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgaa_pkg
// Shared constants and register map of the range gated aperture averager.
// ----------------------------------------------------------------------------
package rgaa_pkg;

  // trace geometry
  localparam int MAX_LENGTH   = 1024;
  localparam int MAX_APERTURE = 16;
  localparam int MAX_SEGMENTS = 4;
  localparam int STOP_REGS    = 4;
  localparam int SAMPLE_WIDTH = 16;

  // derived widths
  localparam int ADDR_W = $clog2(MAX_LENGTH);
  localparam int POS_W  = ADDR_W + 1;
  localparam int TC_W   = $clog2(MAX_APERTURE);
  localparam int N_W    = TC_W + 1;
  localparam int SEG_W  = $clog2(MAX_SEGMENTS);
  localparam int ACC_W  = SAMPLE_WIDTH + TC_W;
  localparam int CNT_W  = 3;
  localparam int STOP_W = 10;
  localparam int FIELD_W = 16;
  localparam int DATA_W  = 48;

  // configuration port
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // register indexes (byte address is 4 * index)
  typedef enum logic [2:0] {
    REG_APERTURE_SIZE = 3'd0,
    REG_SEGMENT_COUNT = 3'd1,
    REG_STOP_0        = 3'd2,
    REG_STOP_1        = 3'd3,
    REG_STOP_2        = 3'd4,
    REG_STOP_3        = 3'd5
  } reg_index_t;

  // reset values
  localparam logic [N_W-1:0]    APERTURE_RESET = N_W'(16);
  localparam logic [CNT_W-1:0]  SEGMENTS_RESET = CNT_W'(4);
  localparam logic [STOP_W-1:0] STOP_0_RESET   = STOP_W'(255);
  localparam logic [STOP_W-1:0] STOP_1_RESET   = STOP_W'(511);
  localparam logic [STOP_W-1:0] STOP_2_RESET   = STOP_W'(767);
  localparam logic [STOP_W-1:0] STOP_3_RESET   = STOP_W'(1023);

endpackage

@@ src/range_gated_aperture_averager.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_gated_aperture_averager
// Collects radar traces of one azimuth and emits a range-gated average trace.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis_* carries echo samples, one per beat; tlast marks the final sample
//   of each trace. m_axis_* carries one averaged sample per input beat while
//   the final trace of a collection streams in; tlast copies the input tlast.
//   Registers are written over the APB port while the stream is idle.
// Throughput and pipeline:
//   one beat per cycle sustained, except while m_axis holds off a result. The
//   accumulator memory read is registered along with the input beat, and
//   the add feeds the output register that drives m_axis.
//   The accumulator memory has one write and one read port; back-to-back hits
//   on one position are forwarded.
// Reset:
//   clears the trace counter, sample position, held azimuth and frame, and
//   loads the register defaults. The accumulator memory is not cleared: the
//   first trace of every collection overwrites each entry it touches.
// Stalls:
//   when m_axis is held off, one result waits in the output register and the
//   next input beat may still enter; s_axis_tready drops only once that beat
//   also has a result waiting behind the output register.
// ----------------------------------------------------------------------------
module range_gated_aperture_averager (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [15:0] sample_value, [31:16] trace_azimuth, [47:32] trace_frame
  input  logic [rgaa_pkg::DATA_W-1:0]       s_axis_tdata,
  input  logic                              s_axis_tlast,
  // output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [15:0] averaged_value, [31:16] out_azimuth, [47:32] out_frame
  output logic [rgaa_pkg::DATA_W-1:0]       m_axis_tdata,
  output logic                              m_axis_tlast,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rgaa_pkg::PADDR_W-1:0]      paddr,
  input  logic [rgaa_pkg::PDATA_W-1:0]      pwdata,
  output logic [rgaa_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready
);

  localparam int ADDR_W = rgaa_pkg::ADDR_W;
  localparam int POS_W  = rgaa_pkg::POS_W;
  localparam int TC_W   = rgaa_pkg::TC_W;
  localparam int N_W    = rgaa_pkg::N_W;
  localparam int SEG_W  = rgaa_pkg::SEG_W;
  localparam int ACC_W  = rgaa_pkg::ACC_W;
  localparam int SW     = rgaa_pkg::SAMPLE_WIDTH;
  localparam int FW     = rgaa_pkg::FIELD_W;
  localparam int CNT_W  = rgaa_pkg::CNT_W;
  localparam int STOP_W = rgaa_pkg::STOP_W;
  localparam int PDW    = rgaa_pkg::PDATA_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [N_W-1:0]    aperture_size;
  logic [CNT_W-1:0]  segment_count;
  logic [STOP_W-1:0] stop_reg [rgaa_pkg::STOP_REGS];

  rgaa_pkg::reg_index_t reg_sel;
  logic                 cfg_write;

  assign reg_sel   = rgaa_pkg::reg_index_t'(paddr[rgaa_pkg::PADDR_W-1:2]);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  // register write
  always_ff @(posedge clk) begin
    if (rst) begin
      aperture_size <= rgaa_pkg::APERTURE_RESET;
      segment_count <= rgaa_pkg::SEGMENTS_RESET;
      stop_reg[0]   <= rgaa_pkg::STOP_0_RESET;
      stop_reg[1]   <= rgaa_pkg::STOP_1_RESET;
      stop_reg[2]   <= rgaa_pkg::STOP_2_RESET;
      stop_reg[3]   <= rgaa_pkg::STOP_3_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        rgaa_pkg::REG_APERTURE_SIZE: aperture_size <= pwdata[N_W-1:0];
        rgaa_pkg::REG_SEGMENT_COUNT: segment_count <= pwdata[CNT_W-1:0];
        rgaa_pkg::REG_STOP_0:        stop_reg[0]   <= pwdata[STOP_W-1:0];
        rgaa_pkg::REG_STOP_1:        stop_reg[1]   <= pwdata[STOP_W-1:0];
        rgaa_pkg::REG_STOP_2:        stop_reg[2]   <= pwdata[STOP_W-1:0];
        rgaa_pkg::REG_STOP_3:        stop_reg[3]   <= pwdata[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      rgaa_pkg::REG_APERTURE_SIZE: prdata = PDW'(aperture_size);
      rgaa_pkg::REG_SEGMENT_COUNT: prdata = PDW'(segment_count);
      rgaa_pkg::REG_STOP_0:        prdata = PDW'(stop_reg[0]);
      rgaa_pkg::REG_STOP_1:        prdata = PDW'(stop_reg[1]);
      rgaa_pkg::REG_STOP_2:        prdata = PDW'(stop_reg[2]);
      rgaa_pkg::REG_STOP_3:        prdata = PDW'(stop_reg[3]);
      default:                     prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // input decode and collection control
  // --------------------------------------------------------------------------
  logic signed [SW-1:0] in_sample;
  logic [FW-1:0]        in_azimuth;
  logic [FW-1:0]        in_frame;

  assign in_sample  = s_axis_tdata[SW-1:0];
  assign in_azimuth = s_axis_tdata[2*FW-1:FW];
  assign in_frame   = s_axis_tdata[3*FW-1:2*FW];

  logic [TC_W-1:0]  trace_counter;
  logic [TC_W-1:0]  trace_counter_next;
  logic [POS_W-1:0] sample_position;
  logic [POS_W-1:0] sample_position_next;
  logic [FW-1:0]    held_azimuth;
  logic [FW-1:0]    held_frame;

  logic             s_acc;
  logic [N_W-1:0]   n_eff;
  logic [CNT_W-1:0] seg_limit;
  logic [TC_W-1:0]  tc_eff;
  logic             new_collection;
  logic [FW-1:0]    azimuth_eff;
  logic [FW-1:0]    frame_eff;
  logic             is_final;

  assign s_acc = s_axis_tvalid && s_axis_tready;

  // clamp aperture size and segment count
  always_comb begin
    if (aperture_size < N_W'(2)) begin
      n_eff = N_W'(2);
    end else if (aperture_size > N_W'(rgaa_pkg::MAX_APERTURE)) begin
      n_eff = N_W'(rgaa_pkg::MAX_APERTURE);
    end else begin
      n_eff = aperture_size;
    end
    if (segment_count > CNT_W'(rgaa_pkg::MAX_SEGMENTS)) begin
      seg_limit = CNT_W'(rgaa_pkg::MAX_SEGMENTS);
    end else begin
      seg_limit = segment_count;
    end
  end

  // azimuth change restarts the collection on the first sample of a trace
  always_comb begin
    tc_eff = trace_counter;
    if (sample_position == '0 && trace_counter != '0 && in_azimuth != held_azimuth) begin
      tc_eff = '0;
    end
    new_collection = (sample_position == '0) && (tc_eff == '0);
    azimuth_eff    = new_collection ? in_azimuth : held_azimuth;
    frame_eff      = new_collection ? in_frame : held_frame;
    is_final       = N_W'(tc_eff) >= (n_eff - N_W'(1));
  end

  // segment lookup: lowest segment whose range holds the position
  logic             seg_found;
  logic [SEG_W-1:0] seg_idx;
  logic [POS_W-1:0] seg_start;

  always_comb begin
    seg_found = 1'b0;
    seg_idx   = '0;
    for (int k = 0; k < rgaa_pkg::MAX_SEGMENTS; k++) begin
      seg_start = (k == 0) ? '0 : (POS_W'(stop_reg[(k == 0) ? 0 : k - 1]) + POS_W'(1));
      if (!seg_found && CNT_W'(k) < seg_limit && sample_position >= seg_start &&
          sample_position <= POS_W'(stop_reg[k])) begin
        seg_found = 1'b1;
        seg_idx   = SEG_W'(k);
      end
    end
  end

  // antenna window of the segment
  logic [N_W:0] ant_count;
  logic         seg_ok;
  logic [N_W:0] win_lo;
  logic [N_W:0] win_hi;
  logic         in_window;

  always_comb begin
    ant_count = (N_W+1)'(2) << seg_idx;
    seg_ok    = seg_found && (ant_count <= (N_W+1)'(n_eff));
    win_lo    = ((N_W+1)'(n_eff) >> ((SEG_W+1)'(seg_idx) + (SEG_W+1)'(1))) - (N_W+1)'(1);
    win_hi    = win_lo + ant_count - (N_W+1)'(1);
    in_window = seg_ok && ((N_W+1)'(tc_eff) >= win_lo) && ((N_W+1)'(tc_eff) <= win_hi);
  end

  // counter and position update
  always_comb begin
    trace_counter_next   = tc_eff;
    sample_position_next = sample_position;
    if (s_axis_tlast) begin
      sample_position_next = '0;
      trace_counter_next   = is_final ? '0 : tc_eff + TC_W'(1);
    end else if (sample_position < POS_W'(rgaa_pkg::MAX_LENGTH)) begin
      sample_position_next = sample_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      trace_counter   <= '0;
      sample_position <= '0;
      held_azimuth    <= '0;
      held_frame      <= '0;
    end else if (s_acc) begin
      trace_counter   <= trace_counter_next;
      sample_position <= sample_position_next;
      held_azimuth    <= azimuth_eff;
      held_frame      <= frame_eff;
    end
  end

  // --------------------------------------------------------------------------
  // accumulate stage: memory read data plus the sample
  // --------------------------------------------------------------------------
  logic                   s1_valid;
  logic signed [SW-1:0]   s1_sample;
  logic [ADDR_W-1:0]      s1_addr;
  logic                   s1_in_mem;
  logic                   s1_clear;
  logic                   s1_add;
  logic                   s1_final;
  logic                   s1_seg_ok;
  logic [SEG_W-1:0]       s1_seg;
  logic                   s1_last;
  logic [FW-1:0]          s1_azimuth;
  logic [FW-1:0]          s1_frame;
  logic signed [ACC_W-1:0] rd_data;
  logic                   fwd;
  logic signed [ACC_W-1:0] fwd_data;
  logic                   s1_adv;

  logic signed [ACC_W-1:0] acc_base;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] acc_shifted;
  logic signed [SW-1:0]    avg_value;

  logic signed [ACC_W-1:0] range_accumulators [rgaa_pkg::MAX_LENGTH];

  assign s1_adv        = s1_valid && (!s1_final || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || s1_adv;

  // sum, floor divide by the antenna count
  always_comb begin
    if (s1_clear) begin
      acc_base = '0;
    end else if (fwd) begin
      acc_base = fwd_data;
    end else begin
      acc_base = rd_data;
    end
    acc_sum     = acc_base + (s1_add ? ACC_W'(s1_sample) : ACC_W'(0));
    acc_shifted = acc_sum >>> ((SEG_W+1)'(s1_seg) + (SEG_W+1)'(1));
    avg_value   = s1_seg_ok ? acc_shifted[SW-1:0] : '0;
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // stage payload and forwarding of a same-position write
  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_sample  <= in_sample;
      s1_addr    <= sample_position[ADDR_W-1:0];
      s1_in_mem  <= sample_position < POS_W'(rgaa_pkg::MAX_LENGTH);
      s1_clear   <= tc_eff == '0;
      s1_add     <= in_window;
      s1_final   <= is_final;
      s1_seg_ok  <= seg_ok;
      s1_seg     <= seg_idx;
      s1_last    <= s_axis_tlast;
      s1_azimuth <= azimuth_eff;
      s1_frame   <= frame_eff;
      fwd        <= s1_adv && s1_in_mem && (s1_addr == sample_position[ADDR_W-1:0]);
      fwd_data   <= acc_sum;
    end
  end

  // accumulator memory
  always_ff @(posedge clk) begin
    if (s1_adv && s1_in_mem) begin
      range_accumulators[s1_addr] <= acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      rd_data <= range_accumulators[sample_position[ADDR_W-1:0]];
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_adv && s1_final) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_final) begin
      m_axis_tdata <= {s1_frame, s1_azimuth, avg_value};
      m_axis_tlast <= s1_last;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_pos_saturates: assert property (@(posedge clk) disable iff (rst)
    sample_position <= POS_W'(rgaa_pkg::MAX_LENGTH))
    else $error("sample position beyond trace limit");

  a_last_rewinds: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tlast |=> sample_position == '0)
    else $error("sample position not rewound after last sample");

  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    s_acc && s_axis_tlast && is_final |=> trace_counter == '0)
    else $error("trace counter not cleared after final trace");

  a_bad_seg_zero: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_final && !s1_seg_ok |=> m_axis_tvalid && m_axis_tdata[SW-1:0] == '0)
    else $error("uncovered position gave a nonzero average");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_final |=> m_axis_tvalid && m_axis_tdata[2*FW-1:FW] == $past(s1_azimuth))
    else $error("result lost or azimuth wrong");

endmodule
